// File: rtl/capf_pkg.sv
// ---------------------------------------------------------------------------
// Capability finder package
// Shared constants and command types for the capability finder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package capf_pkg;

   localparam int CONFIG_DWORDS   = 64;
   localparam int DWORD_AW        = $clog2(CONFIG_DWORDS);
   localparam int DEF_MAX_HOPS    = 48;
   localparam int QUEUE_DEPTH     = 2;

   // Fixed locations within the configuration header, as dword indexes.
   localparam logic [DWORD_AW-1:0] STATUS_DWORD  = DWORD_AW'(8'h06 >> 2);
   localparam logic [DWORD_AW-1:0] CAP_PTR_DWORD = DWORD_AW'(8'h34 >> 2);
   // Capabilities List bit: bit 4 of the status halfword at byte 0x06.
   localparam int CAP_LIST_BIT    = 8 * (8'h06 % 4) + 4;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_FIND  = 1'b1
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [DWORD_AW-1:0] index;
      logic [31:0]         data;
      logic [7:0]          cap_id;
   } cmd_type;

endpackage

`default_nettype wire

// File: rtl/capf_front.sv
// ---------------------------------------------------------------------------
// Capability finder front end
// Accepts request transfers, decodes them into commands and holds one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module capf_front
   import capf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,
   input  wire logic        req_tuser,
   output logic             cmd_valid,
   input  wire logic        cmd_ready,
   output cmd_type          cmd
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;

   assign req_tready = !valid_ff || cmd_ready;

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (valid_ff && cmd_ready) begin
         valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         valid_in      = 1'b1;
         cmd_in.op     = req_tuser ? OP_FIND : OP_WRITE;
         cmd_in.index  = req_tdata[DWORD_AW-1:0];
         cmd_in.data   = req_tdata[37:6];
         cmd_in.cap_id = req_tdata[45:38];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

`default_nettype wire

// File: rtl/capf_queue.sv
// ---------------------------------------------------------------------------
// Capability finder command queue
// Short first-in first-out store between the front end and the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module capf_queue
   import capf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire cmd_type push_cmd,
   output logic         pop_valid,
   input  wire logic    pop,
   output cmd_type      pop_cmd
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type       entry_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != CW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// File: rtl/capf_back.sv
// ---------------------------------------------------------------------------
// Capability finder back end
// Holds the configuration image, performs writes and walks the list.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module capf_back
   import capf_pkg::*;
#(
   parameter int MAX_HOPS = DEF_MAX_HOPS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   output logic         cmd_pop,
   input  wire cmd_type cmd,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output logic [7:0]   rsp_tdata,
   output logic         rsp_tuser
);

   localparam int HOP_W = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STATUS,
      ST_PTR,
      ST_HOP
   } state_type;

   state_type           state_ff, state_in;
   logic [31:0]         image_ff [CONFIG_DWORDS];
   logic [31:0]         rd_data_ff;
   logic [DWORD_AW-1:0] rd_addr;
   logic [DWORD_AW-1:0] cursor_ff, cursor_in, next_dw;
   logic [HOP_W-1:0]    hop_ff, hop_in;
   logic [7:0]          want_ff, want_in;
   logic                valid_ff, valid_in, found_ff, found_in;
   logic [7:0]          offset_ff, offset_in;

   // The cursor is always dword aligned, so the id byte and the next
   // pointer of a capability header share one dword.
   assign next_dw = rd_data_ff[15:10];

   always_comb begin
      unique case (state_ff)
         ST_IDLE:   rd_addr = STATUS_DWORD;
         ST_STATUS: rd_addr = CAP_PTR_DWORD;
         ST_PTR:    rd_addr = rd_data_ff[7:2];
         ST_HOP:    rd_addr = next_dw;
         default:   rd_addr = STATUS_DWORD;
      endcase
   end

   always_comb begin
      cmd_pop = (state_ff == ST_IDLE) && cmd_valid &&
                (cmd.op == OP_WRITE || !valid_ff);
   end

   always_comb begin
      state_in  = state_ff;
      cursor_in = cursor_ff;
      hop_in    = hop_ff;
      want_in   = want_ff;
      valid_in  = valid_ff && !rsp_tready;
      found_in  = found_ff;
      offset_in = offset_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_pop && cmd.op == OP_FIND) begin
               want_in  = cmd.cap_id;
               state_in = ST_STATUS;
            end
         end
         ST_STATUS: begin
            if (!rd_data_ff[CAP_LIST_BIT]) begin
               valid_in  = 1'b1;
               found_in  = 1'b0;
               offset_in = '0;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_PTR;
            end
         end
         ST_PTR: begin
            cursor_in = rd_data_ff[7:2];
            hop_in    = '0;
            if (rd_data_ff[7:2] == '0) begin
               valid_in  = 1'b1;
               found_in  = 1'b0;
               offset_in = '0;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_HOP;
            end
         end
         ST_HOP: begin
            if (rd_data_ff[7:0] == want_ff) begin
               valid_in  = 1'b1;
               found_in  = 1'b1;
               offset_in = {cursor_ff, 2'b00};
               state_in  = ST_IDLE;
            end else if (next_dw == cursor_ff || next_dw == '0 ||
                         hop_ff == HOP_W'(MAX_HOPS - 1)) begin
               valid_in  = 1'b1;
               found_in  = 1'b0;
               offset_in = '0;
               state_in  = ST_IDLE;
            end else begin
               cursor_in = next_dw;
               hop_in    = hop_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      cursor_ff <= cursor_in;
      hop_ff    <= hop_in;
      want_ff   <= want_in;
      found_ff  <= found_in;
      offset_ff <= offset_in;
   end

   // Configuration image: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd_pop && cmd.op == OP_WRITE) begin
         image_ff[cmd.index] <= cmd.data;
      end
      rd_data_ff <= image_ff[rd_addr];
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = found_ff;
   assign rsp_tdata  = offset_ff;

endmodule

`default_nettype wire

// File: rtl/pci_capability_finder.sv
// ---------------------------------------------------------------------------
// PCI capability finder
// Keeps a 256-byte configuration-space image and walks its capability list.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Carries
//   req_     in         tuser = kind, tdata = dword_index, write_data, cap_id
//   rsp_     out        tuser = found, tdata = hdr_offset (finds only)
//
// A write transfer is stored in the image at the edge at which it leaves the
// command queue.
// A find makes one image read per cycle on the single read port: status,
// pointer, then one read per hop, and the last header read is judged too;
// at most MAX_HOPS headers are judged, and a clear Capabilities List bit
// ends the find after the status read. A request passes through the front
// register and the queue before it reaches the walk.
// Reset clears the control state only; image entries are undefined until
// written and there is no clearing pass.
// A stalled response holds in the output register; writes ahead of the next
// find still enter the image; that find waits until the response is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pci_capability_finder
   import capf_pkg::*;
#(
   parameter int MAX_HOPS = DEF_MAX_HOPS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [5:0] dword_index, [37:6] write_data, [45:38] cap_id, [47:46] zero
   input  wire logic [47:0] req_tdata,
   // [0] kind: 0 writes a dword, 1 finds a capability
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] hdr_offset
   output logic [7:0]       rsp_tdata,
   // [0] found
   output logic             rsp_tuser
);

   cmd_type front_cmd, queue_cmd;
   logic    front_valid, front_ready;
   logic    queue_valid, queue_pop;

   // Front end: takes request transfers and decodes the kind.
   capf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd        (front_cmd)
   );

   // The queue lets the front end keep accepting while a walk is running.
   capf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (queue_valid),
      .pop        (queue_pop),
      .pop_cmd    (queue_cmd)
   );

   // Back end: image store, list walker and the response register.
   capf_back #(
      .MAX_HOPS (MAX_HOPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (queue_valid),
      .cmd_pop    (queue_pop),
      .cmd        (queue_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// File: rtl/capf_checker.sv
// ---------------------------------------------------------------------------
// Capability finder checker
// Port-level assertions on the response channel, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module capf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tuser
);

   // A response is never shown in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid straight after reset");

   // A stalled response holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // A miss always reports offset zero.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 8'h00)
      else $error("miss with non-zero offset");

   // A hit is dword aligned and never at offset zero.
   a_hit_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[1:0] == 2'b00 && rsp_tdata != 8'h00)
      else $error("hit at an unaligned or null offset");

endmodule

bind pci_capability_finder capf_checker u_capf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// File: test/pci_capability_finder_tb.sv
// ---------------------------------------------------------------------------
// PCI capability finder testbench
// Loads configuration-space images into the block and searches for
// capability ids. Directed chains cover the corner cases of the walk, and a
// long random run follows. A scoreboard predicts each lookup from its own
// copy of the image and checks every response transfer in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pci_capability_finder_tb;
   import capf_pkg::*;

   localparam int CLOCK_PERIOD = 4;
   localparam int RESET_CYCLES = 9;
   localparam int WALK_HOPS    = DEF_MAX_HOPS;
   localparam int ITEM_TARGET  = 1700;
   localparam int MAX_REPORTS  = 10;
   // Longest legal stretch without any transfer is one full walk behind a
   // stalled receiver; this allows many times that.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = WALK_HOPS + 8;

   // Fixed header bytes and the pointer mask used by the walk.
   localparam logic [7:0] STATUS_BYTE  = 8'h06;
   localparam logic [7:0] CAP_PTR_BYTE = 8'h34;
   localparam logic [7:0] PTR_MASK     = 8'hFC;
   localparam int         CAPS_BIT     = 4;
   localparam logic [5:0] STATUS_INDEX  = 6'(STATUS_BYTE >> 2);
   localparam logic [5:0] CAP_PTR_INDEX = 6'(CAP_PTR_BYTE >> 2);
   // Bit of the status dword that holds the Capabilities List flag.
   localparam int CAPS_DWORD_BIT = 8 * (STATUS_BYTE % 4) + CAPS_BIT;

   typedef struct packed {
      logic       found;
      logic [7:0] offset;
   } lookup_result_type;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_pattern_type;

   // ------------------------------------------------------------------------
   // Scoreboard: mirrors the configuration image, predicts every lookup when
   // its request transfer is accepted and matches responses in order.
   // ------------------------------------------------------------------------
   class capability_walk_check;
      logic [31:0]       image [CONFIG_DWORDS];
      lookup_result_type pending_lookups[$];
      int                mismatches;

      function new();
         mismatches = 0;
         foreach (image[i]) image[i] = '0;
      endfunction

      function logic [7:0] image_byte(logic [7:0] off);
         logic [31:0] word;
         word = image[off[7:2]];
         return word[8 * off[1:0] +: 8];
      endfunction

      // Follows the capability list for one id, stopping on a match, a null
      // pointer, a pointer back to the same header, or the hop limit.
      function lookup_result_type walk_capabilities(logic [7:0] want);
         lookup_result_type res;
         logic [15:0]       status;
         logic [7:0]        cursor;
         logic [7:0]        nxt;
         int                hop;
         res    = '0;
         status = {image_byte(STATUS_BYTE + 8'd1), image_byte(STATUS_BYTE)};
         if (!status[CAPS_BIT]) return res;
         cursor = image_byte(CAP_PTR_BYTE) & PTR_MASK;
         for (hop = 0; hop < WALK_HOPS && cursor != 8'h00; hop++) begin
            if (image_byte(cursor) == want) begin
               res.found  = 1'b1;
               res.offset = cursor;
               return res;
            end
            nxt = image_byte(cursor + 8'd1) & PTR_MASK;
            if (nxt == cursor) break;
            cursor = nxt;
         end
         return res;
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
      endfunction

      function void note_request(op_type op, logic [47:0] payload);
         if (op == OP_WRITE) image[payload[5:0]] = payload[37:6];
         else pending_lookups.push_back(walk_capabilities(payload[45:38]));
      endfunction

      function void check_response(logic found, logic [7:0] offset);
         lookup_result_type want;
         if (pending_lookups.size() == 0) begin
            report($sformatf("response found=%0d offset=0x%02h with no lookup pending",
                             found, offset));
            return;
         end
         want = pending_lookups.pop_front();
         if (found !== want.found || offset !== want.offset)
            report($sformatf("found expected %0d got %0d, offset expected 0x%02h got 0x%02h",
                             want.found, found, want.offset, offset));
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Clock, reset and the block's inputs. Every input starts at a known value.
   // ------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [47:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tready = 1'b0;
   wire logic   req_tready;
   wire logic   rsp_tvalid;
   wire logic [7:0] rsp_tdata;
   wire logic   rsp_tuser;

   capability_walk_check walk_check = new();

   int                items_sent  = 0;
   int                burst_left  = 0;
   int                idle_cycles = 0;
   ready_pattern_type ready_mode  = READY_ALWAYS;
   int                ready_left  = 0;
   int                ready_phase = 0;

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   pci_capability_finder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      // [5:0] dword_index, [37:6] write_data, [45:38] cap_id, [47:46] zero
      .req_tdata  (req_tdata),
      // [0] kind
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // [7:0] hdr_offset
      .rsp_tdata  (rsp_tdata),
      // [0] found
      .rsp_tuser  (rsp_tuser)
   );

   // ------------------------------------------------------------------------
   // Monitors. Both channels are sampled at the rising edge, before the
   // nonblocking updates of that edge land. Responses are checked ahead of
   // new requests so that a lookup never meets its own response early.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) walk_check.check_response(rsp_tuser, rsp_tdata);
         if (req_tvalid && req_tready) walk_check.note_request(op_type'(req_tuser), req_tdata);
      end
   end

   // The watchdog counts cycles in which neither channel completes a transfer.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // The receiver switches between stall patterns of random duration, one of
   // them never stalling, so that backpressure lands on every phase of a walk.
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode = ready_pattern_type'($urandom_range(READY_ALWAYS, READY_PERIODIC));
         ready_left = $urandom_range(20, 300);
      end
      ready_left--;
      ready_phase++;
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:      rsp_tready <= (ready_phase % 6) < 2;
      endcase
   end

   // ------------------------------------------------------------------------
   // Request driver. The sender works in bursts of random length; a gap may
   // open before each burst. Valid stays high from one transfer to the next
   // inside a burst, so it is never lowered and raised in the same step.
   // ------------------------------------------------------------------------
   task automatic send_item(input op_type op, input logic [5:0] idx,
                            input logic [31:0] data, input logic [7:0] id);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, id, data, idx};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Unused fields of each kind carry random bits, which the block ignores.
   task automatic write_dword(input logic [5:0] idx, input logic [31:0] data);
      send_item(OP_WRITE, idx, data, 8'($urandom));
   endtask

   task automatic find_cap(input logic [7:0] id);
      send_item(OP_FIND, 6'($urandom), $urandom, id);
   endtask

   // A capability header: id in the first byte, next pointer in the second.
   task automatic write_node(input logic [7:0] off, input logic [7:0] id,
                             input logic [7:0] next);
      write_dword(off[7:2], {16'($urandom), next, id});
   endtask

   // Status dword with the Capabilities List flag, then the list pointer.
   task automatic set_header(input logic caps, input logic [7:0] ptr);
      logic [31:0] status_word;
      status_word = $urandom;
      status_word[CAPS_DWORD_BIT] = caps;
      write_dword(STATUS_INDEX, status_word);
      write_dword(CAP_PTR_INDEX, {24'($urandom), ptr});
   endtask

   // Holds the sender off until every predicted lookup has been answered.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (walk_check.pending_lookups.size() != 0) @(posedge clock);
   endtask

   // A random capability list ending in a null pointer or a loop, then lookups
   // with ids mostly taken from the list and the odd stray write in between.
   task automatic random_chain();
      logic [5:0] slots [48];
      logic [7:0] node_ids [48];
      logic [5:0] tmp;
      logic [7:0] off;
      logic [7:0] next;
      int         len;
      int         ending;
      int         j;
      int         lookups;
      foreach (slots[i]) slots[i] = 6'(16 + i);
      for (int i = 47; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = slots[i];
         slots[i] = slots[j];
         slots[j] = tmp;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      ending = $urandom_range(0, 7);
      set_header($urandom_range(0, 9) != 0, {slots[0], 2'($urandom)});
      for (int i = 0; i < len; i++) begin
         node_ids[i] = 8'($urandom);
         off = {slots[i], 2'b00};
         if (i < len - 1) next = {slots[i + 1], 2'($urandom)};
         else if (ending == 0) next = off | 8'(2'($urandom));
         else if (ending == 1) next = {slots[$urandom_range(0, i)], 2'($urandom)};
         else next = {6'd0, 2'($urandom)};
         write_node(off, node_ids[i], next);
      end
      lookups = $urandom_range(2, 8);
      for (int i = 0; i < lookups; i++) begin
         if ($urandom_range(0, 7) == 0) write_dword(6'($urandom), $urandom);
         if ($urandom_range(0, 99) < 65) find_cap(node_ids[$urandom_range(0, len - 1)]);
         else find_cap(8'($urandom));
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin
      logic [31:0] word;
      int          scenario;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The image is undefined after reset, so every dword is written first.
      for (int i = 0; i < CONFIG_DWORDS; i++) write_dword(6'(i), $urandom);

      // Capabilities List flag clear: nothing is ever found.
      set_header(1'b0, 8'h40);
      find_cap(8'h00);
      find_cap(8'hFF);

      // A list pointer whose upper bits are zero is a null pointer.
      set_header(1'b1, 8'h03);
      find_cap(8'h01);

      // A header whose next pointer leads back to itself.
      write_node(8'h40, 8'h05, 8'h42);
      set_header(1'b1, 8'h41);
      find_cap(8'h05);
      find_cap(8'h06);

      // Forty-eight headers in a row: the last one is found on the final hop
      // and the one behind it lies beyond the hop limit.
      for (int i = 0; i < 48; i++)
         write_node(8'h40 + 8'(4 * i), 8'(i + 1),
                    (i == 47) ? 8'h3B : (8'h44 + 8'(4 * i)) | 8'(2'($urandom)));
      write_node(8'h38, 8'hEE, 8'h00);
      set_header(1'b1, 8'h40);
      find_cap(8'd48);
      find_cap(8'd47);
      find_cap(8'hEE);

      // Two headers pointing at each other spin until the hop limit.
      write_node(8'h84, 8'h22, 8'h80);
      find_cap(8'h30);
      find_cap(8'd17);

      // Highest header offset with the highest id.
      write_node(8'hFC, 8'hFF, 8'h00);
      set_header(1'b1, 8'hFF);
      find_cap(8'hFF);

      // Lowest usable offset: the header shares its dword with the status.
      word = $urandom;
      word[15:0] = 16'h0000;
      word[CAPS_DWORD_BIT] = 1'b1;
      write_dword(STATUS_INDEX, word);
      write_dword(CAP_PTR_INDEX, {24'($urandom), 8'h04});
      find_cap(8'h00);

      wait_drained();

      scenario = 0;
      while (items_sent < ITEM_TARGET) begin
         random_chain();
         scenario++;
         if (scenario % 16 == 0) wait_drained();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (walk_check.pending_lookups.size() != 0)
         walk_check.report($sformatf("%0d lookups never answered",
                                     walk_check.pending_lookups.size()));
      if (walk_check.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/capf_pkg.sv
rtl/capf_front.sv
rtl/capf_queue.sv
rtl/capf_back.sv
rtl/pci_capability_finder.sv
rtl/capf_checker.sv
test/pci_capability_finder_tb.sv
